>>> hdl/itba_pkg.sv
// itba_pkg: shared constants, state type and character helpers for the
// integer-to-ASCII converter. No dependencies.
`default_nettype none

package itba_pkg;

  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 7;
  localparam int DIGIT_W = 6;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  localparam logic [DIGIT_W-1:0] DIGIT_LIMIT   = 6'd10;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_LETTER_A = 7'h61;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS    = 7'h2d;

  typedef enum logic [1:0] {
    BACK_IDLE,
    BACK_DIV,
    BACK_SIGN,
    BACK_EMIT
  } back_state_t;

  // clamp the programmed base into 2..36
  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // digit value to '0'..'9' or 'a'..'z'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_LIMIT) begin
      res = CHAR_ZERO + {1'b0, d};
    end else begin
      res = CHAR_LETTER_A + {1'b0, d - DIGIT_LIMIT};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/itba_fifo.sv
// itba_fifo: small register-based first-in first-out queue.
// Standalone, no package dependencies.
`default_nettype none

module itba_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/itba_front.sv
// itba_front: accepts integers, splits them into sign and unsigned magnitude
// and queues them for the conversion engine. Uses itba_fifo.
`default_nettype none

module itba_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output logic                        full,
  input  wire logic                   q_pop,
  output logic                        q_empty,
  output logic                        q_neg,
  output logic      [VALUE_WIDTH-1:0] q_mag
);

  logic                   neg;
  logic [VALUE_WIDTH-1:0] mag;

  // unsigned negate, so the most negative value keeps its magnitude
  assign neg = value[VALUE_WIDTH-1];
  assign mag = neg ? (~value + 1'b1) : value;

  itba_fifo #(
    .WIDTH(VALUE_WIDTH + 1),
    .DEPTH(2)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data({neg, mag}),
    .full   (full),
    .pop    (q_pop),
    .rd_data({q_neg, q_mag}),
    .empty  (q_empty)
  );

endmodule

`default_nettype wire

>>> hdl/itba_div.sv
// itba_div: iterative restoring divider of a wide magnitude by a 6-bit base,
// eight quotient bits per cycle. Uses itba_pkg.
`default_nettype none

module itba_div #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [VALUE_WIDTH-1:0]          dividend,
  input  wire logic [itba_pkg::RADIX_W-1:0]    divisor,
  output logic                                 done,
  output logic      [VALUE_WIDTH-1:0]          quotient,
  output logic      [itba_pkg::RADIX_W-1:0]    remainder
);

  localparam int STEPS = 8;
  localparam int NCYC  = (VALUE_WIDTH + STEPS - 1) / STEPS;
  localparam int PW    = NCYC * STEPS;
  localparam int CNT_W = $clog2(NCYC + 1);
  localparam int RW    = itba_pkg::RADIX_W;

  logic [PW-1:0]    acc;
  logic [RW-1:0]    rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [PW-1:0]    acc_next;
  logic [RW-1:0]    rem_next;

  // eight shift-compare-subtract steps on a 7-bit partial remainder
  always_comb begin
    logic [RW:0] t;
    acc_next = acc;
    rem_next = rem;
    for (int i = 0; i < STEPS; i++) begin
      t        = {rem_next, acc_next[PW-1]};
      acc_next = {acc_next[PW-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        rem_next    = RW'(t - {1'b0, divisor});
        acc_next[0] = 1'b1;
      end else begin
        rem_next = t[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= PW'(dividend);
      rem <= '0;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NCYC);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = acc[VALUE_WIDTH-1:0];
  assign remainder = rem;

endmodule

`default_nettype wire

>>> hdl/itba_back.sv
// itba_back: conversion engine; repeated division into a digit stack, then
// sign and digits out most significant first. Uses itba_pkg and itba_div.
`default_nettype none

module itba_back #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_empty,
  output logic                                 q_pop,
  input  wire logic                            q_neg,
  input  wire logic [VALUE_WIDTH-1:0]          q_mag,
  input  wire logic [itba_pkg::RADIX_W-1:0]    divisor,
  input  wire logic                            out_full,
  output logic                                 out_push,
  output logic      [itba_pkg::CHAR_W-1:0]     out_char,
  output logic                                 out_last
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int DW    = itba_pkg::DIGIT_W;

  itba_pkg::back_state_t state;
  itba_pkg::back_state_t state_next;

  logic [DW-1:0]          stack [VALUE_WIDTH];
  logic [CNT_W-1:0]       ndig;
  logic                   neg;
  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  logic                   div_done;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [DW-1:0]          div_remainder;
  logic                   stack_push;
  logic                   stack_pop;
  logic                   last_digit;

  assign last_digit = (ndig == CNT_W'(1));

  itba_div #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quotient),
    .remainder(div_remainder)
  );

  always_comb begin
    state_next = state;
    case (state)
      itba_pkg::BACK_IDLE: begin
        if (!q_empty) begin
          state_next = itba_pkg::BACK_DIV;
        end
      end
      itba_pkg::BACK_DIV: begin
        if (div_done && (div_quotient == '0)) begin
          state_next = neg ? itba_pkg::BACK_SIGN : itba_pkg::BACK_EMIT;
        end
      end
      itba_pkg::BACK_SIGN: begin
        if (!out_full) begin
          state_next = itba_pkg::BACK_EMIT;
        end
      end
      itba_pkg::BACK_EMIT: begin
        if (!out_full && last_digit) begin
          state_next = itba_pkg::BACK_IDLE;
        end
      end
      default: begin
        state_next = itba_pkg::BACK_IDLE;
      end
    endcase
  end

  always_comb begin
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = q_mag;
    stack_push   = 1'b0;
    stack_pop    = 1'b0;
    out_push     = 1'b0;
    out_char     = itba_pkg::digit_char(stack[0]);
    out_last     = 1'b0;
    case (state)
      itba_pkg::BACK_IDLE: begin
        q_pop     = !q_empty;
        div_start = !q_empty;
      end
      itba_pkg::BACK_DIV: begin
        div_dividend = div_quotient;
        div_start    = div_done && (div_quotient != '0);
        stack_push   = div_done;
      end
      itba_pkg::BACK_SIGN: begin
        out_push = !out_full;
        out_char = itba_pkg::CHAR_MINUS;
      end
      itba_pkg::BACK_EMIT: begin
        out_push  = !out_full;
        out_last  = last_digit;
        stack_pop = !out_full;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // digit stack: newest digit (the most significant so far) sits at the top
  always_ff @(posedge clk) begin
    if (stack_push) begin
      stack[0] <= div_remainder;
      for (int i = 1; i < VALUE_WIDTH; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (stack_pop) begin
      for (int i = 0; i < VALUE_WIDTH - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      neg <= q_neg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itba_pkg::BACK_IDLE;
      ndig  <= '0;
    end else begin
      state <= state_next;
      if (q_pop) begin
        ndig <= '0;
      end else if (stack_push) begin
        ndig <= ndig + 1'b1;
      end else if (stack_pop) begin
        ndig <= ndig - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> hdl/int_to_base_ascii_core.sv
// int_to_base_ascii_core: top level of the signed integer to ASCII converter.
// Uses itba_pkg, itba_front, itba_back and itba_fifo.
`default_nettype none

// Converts each pushed signed integer into ASCII text in the base held in the
// radix register (2..36; 0 and 1 act as 2, 37..63 act as 36; reset value 16).
// One character comes out per result, most significant first: a leading '-'
// for a negative value, then digits '0'..'9' and 'a'..'z'; zero gives "0" and
// the final character of each number carries last_char. The most negative
// value converts exactly because the magnitude is unsigned. Both sides act
// as queues: push/full on the input, empty/pop on the results. A two-entry
// queue sits between the input side and the conversion engine, and a
// two-entry queue holds finished characters, so either side may stall
// without blocking the other. The engine works on one number at a time:
// each digit takes one pass of the divider, and the characters then leave
// one at a time, each as soon as the output queue has room. The radix port
// accepts a write in every cycle; write it only while no number is in flight.

module int_to_base_ascii_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // number input
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [VALUE_WIDTH-1:0]             value,
  // character output
  output logic                                    empty,
  input  wire logic                               pop,
  output logic      [itba_pkg::CHAR_W-1:0]        character,
  output logic                                    last_char,
  // radix register write
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [itba_pkg::RADIX_W-1:0]       cfg_data
);

  logic [itba_pkg::RADIX_W-1:0] radix;
  logic [itba_pkg::RADIX_W-1:0] divisor;

  logic                         q_pop;
  logic                         q_empty;
  logic                         q_neg;
  logic [VALUE_WIDTH-1:0]       q_mag;

  logic                         out_full;
  logic                         out_push;
  logic [itba_pkg::CHAR_W-1:0]  out_char;
  logic                         out_last;

  // radix register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= itba_pkg::RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  // out-of-range bases are clamped, not rejected
  assign divisor = itba_pkg::eff_radix(radix);

  // front: sign/magnitude split and request queue
  itba_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .value  (value),
    .full   (full),
    .q_pop  (q_pop),
    .q_empty(q_empty),
    .q_neg  (q_neg),
    .q_mag  (q_mag)
  );

  // back: divide into digits, then emit sign and digits
  itba_back #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .divisor (divisor),
    .out_full(out_full),
    .out_push(out_push),
    .out_char(out_char),
    .out_last(out_last)
  );

  // finished characters wait here for the consumer
  itba_fifo #(
    .WIDTH(itba_pkg::CHAR_W + 1),
    .DEPTH(2)
  ) u_out_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (out_push),
    .wr_data({out_char, out_last}),
    .full   (out_full),
    .pop    (pop),
    .rd_data({character, last_char}),
    .empty  (empty)
  );

endmodule

`default_nettype wire
